/* src/nearest_obstacle_ring_search_defines.svh */
// Assertion macros used by the top-level file to check its own logic.
`ifndef NEAREST_OBSTACLE_RING_SEARCH_DEFINES_SVH
`define NEAREST_OBSTACLE_RING_SEARCH_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define NORS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nors: same-cycle check failed");
`define NORS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nors: next-cycle check failed");
`else
`define NORS_ASSERT_IMP(label, ante, cons)
`define NORS_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* src/nors_pkg.sv */
package nors_pkg;

    localparam int CW      = 7;
    localparam int DW      = 15;
    localparam int POS_W   = 6;
    localparam int DIST_W  = 13;
    localparam logic [DIST_W-1:0] DIST_MAX = 13'h1FFF;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [0:0] CFG_GRID_W = 1'b0;
    localparam logic [0:0] CFG_GRID_H = 1'b1;

    typedef struct packed {
        logic clr_step;
        logic wr;
        logic load;
        logic ring_setup;
        logic step;
        logic next_ring;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic stop;
        logic seg_final;
        logic pipe_busy;
        logic out_free;
    } t_status;

endpackage

/* src/nors_ram.sv */
module nors_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/nors_ctrl.sv */
module nors_ctrl
    import nors_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_kind,
    output logic    o_in_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RING,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_st.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && (i_in_kind == KIND_QUERY)) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RING;
                end else if (accept) begin
                    o_cmd.wr = 1'b1;
                end
            end
            ST_RING: begin
                if (i_st.stop) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.ring_setup = 1'b1;
                    n_state          = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_st.seg_final) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_st.pipe_busy) begin
                    o_cmd.next_ring = 1'b1;
                    n_state         = ST_RING;
                end
            end
            ST_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/nors_dp.sv */
module nors_dp
    import nors_pkg::*;
#(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_addr,
    input  logic [CW-1:0]     i_cfg_wdata,
    input  logic [POS_W-1:0]  i_cell_x,
    input  logic [POS_W-1:0]  i_cell_y,
    input  logic              i_is_obstacle,
    input  t_cmd              i_cmd,
    output t_status           o_st,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_found,
    output logic [POS_W-1:0]  o_nearest_x,
    output logic [POS_W-1:0]  o_nearest_y,
    output logic [DIST_W-1:0] o_nearest_dist_sq
);

    localparam int Depth = GRID_W * GRID_H;
    localparam int AW    = $clog2(Depth);
    localparam logic [10:0] GridWv = 11'(GRID_W);
    localparam logic [10:0] GridHv = 11'(GRID_H);

    typedef enum logic [1:0] {
        SEG_TOP,
        SEG_BOT,
        SEG_LFT,
        SEG_RGT
    } t_seg;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
        cell_addr = AW'(AW'(y) * AW'(GRID_W)) + AW'(x);
    endfunction

    logic [CW-1:0] r_cfg_w, r_cfg_h;
    logic [AW-1:0] r_clr_cnt;

    logic [CW-1:0] r_px, r_py, r_w, r_h, r_r;
    logic [DW-1:0] r_rsq;
    logic          r_best_valid;
    logic [DW-1:0] r_best_d;
    logic [CW-1:0] r_best_x, r_best_y;

    logic [CW-1:0] r_xlo, r_xhi, r_ylo, r_yhi;
    logic [CW-1:0] r_ytop, r_ybot, r_xl, r_xr;
    logic [3:0]    r_en;
    t_seg          r_seg;
    logic [CW-1:0] r_pos;

    logic          r_p1_vld;
    logic [CW-1:0] r_p1_x, r_p1_y, r_p1_dx, r_p1_dy;
    logic          r_p2_vld;
    logic [DW-1:0] r_p2_d;
    logic [CW-1:0] r_p2_x, r_p2_y;

    logic              r_out_vld;
    logic              r_out_found;
    logic [POS_W-1:0]  r_out_x, r_out_y;
    logic [DIST_W-1:0] r_out_d;

    logic [CW-1:0] q_w, q_h, maxdim;
    logic          in_grid;
    logic [CW:0]   s_ytop, s_xr;
    logic          top, bot, lft, rgt;
    logic          row_seg, seg_en, seg_last;
    logic [CW-1:0] seg_end, probe_x, probe_y, along_ref, along_d;
    logic          probe;
    logic          wr_ok;
    logic          ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic          better;

    assign q_w = (11'(r_cfg_w) < GridWv) ? r_cfg_w : CW'(GRID_W);
    assign q_h = (11'(r_cfg_h) < GridHv) ? r_cfg_h : CW'(GRID_H);

    assign in_grid = (r_px < r_w) && (r_py < r_h);
    assign maxdim  = (r_w > r_h) ? r_w : r_h;

    assign s_ytop = {1'b0, r_py} + {1'b0, r_r};
    assign s_xr   = {1'b0, r_px} + {1'b0, r_r};
    assign top    = s_ytop < {1'b0, r_h};
    assign bot    = r_py >= r_r;
    assign lft    = r_px >= r_r;
    assign rgt    = s_xr < {1'b0, r_w};

    assign row_seg  = (r_seg == SEG_TOP) || (r_seg == SEG_BOT);
    assign seg_end  = row_seg ? r_xhi : r_yhi;
    assign seg_en   = r_en[r_seg];
    assign seg_last = !seg_en || (r_pos == seg_end);
    assign probe    = i_cmd.step && seg_en;

    always_comb begin
        unique case (r_seg)
            SEG_TOP: begin
                probe_x = r_pos;
                probe_y = r_ytop;
            end
            SEG_BOT: begin
                probe_x = r_pos;
                probe_y = r_ybot;
            end
            SEG_LFT: begin
                probe_x = r_xl;
                probe_y = r_pos;
            end
            default: begin
                probe_x = r_xr;
                probe_y = r_pos;
            end
        endcase
    end

    assign along_ref = row_seg ? r_px : r_py;
    assign along_d   = (r_pos >= along_ref) ? (r_pos - along_ref) : (along_ref - r_pos);

    assign wr_ok     = (11'(i_cell_x) < GridWv) && (11'(i_cell_y) < GridHv);
    assign ram_we    = i_cmd.clr_step || (i_cmd.wr && wr_ok);
    assign ram_wdata = i_cmd.clr_step ? 1'b0 : i_is_obstacle;
    assign ram_waddr = i_cmd.clr_step ? r_clr_cnt
                                      : cell_addr(CW'(i_cell_x), CW'(i_cell_y));
    assign ram_raddr = cell_addr(probe_x, probe_y);

    nors_ram #(
        .WIDTH(1),
        .DEPTH(Depth)
    ) u_grid (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign better = r_p2_vld && (!r_best_valid || (r_p2_d < r_best_d));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w      <= CW'(64);
            r_cfg_h      <= CW'(64);
            r_clr_cnt    <= '0;
            r_best_valid <= 1'b0;
            r_p1_vld     <= 1'b0;
            r_p2_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_addr == CFG_GRID_W)) begin
                r_cfg_w <= i_cfg_wdata;
            end
            if (i_cfg_we && (i_cfg_addr == CFG_GRID_H)) begin
                r_cfg_h <= i_cfg_wdata;
            end
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_cmd.load) begin
                r_best_valid <= 1'b0;
            end else if (better) begin
                r_best_valid <= 1'b1;
            end
            r_p1_vld <= probe;
            r_p2_vld <= r_p1_vld && ram_rdata;
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px     <= CW'(i_cell_x);
            r_py     <= CW'(i_cell_y);
            r_w      <= q_w;
            r_h      <= q_h;
            r_r      <= CW'(1);
            r_rsq    <= DW'(1);
            r_best_d <= '1;
            r_best_x <= '0;
            r_best_y <= '0;
        end else begin
            if (i_cmd.next_ring) begin
                r_r   <= r_r + CW'(1);
                r_rsq <= r_rsq + DW'({r_r, 1'b1});
            end
            if (better) begin
                r_best_d <= r_p2_d;
                r_best_x <= r_p2_x;
                r_best_y <= r_p2_y;
            end
        end
        if (i_cmd.ring_setup) begin
            r_xlo  <= lft ? (r_px - r_r) : '0;
            r_xhi  <= rgt ? s_xr[CW-1:0] : (r_w - CW'(1));
            r_ylo  <= bot ? (r_py - r_r + CW'(1)) : '0;
            r_yhi  <= top ? (s_ytop[CW-1:0] - CW'(1)) : (r_h - CW'(1));
            r_ytop <= s_ytop[CW-1:0];
            r_ybot <= r_py - r_r;
            r_xl   <= r_px - r_r;
            r_xr   <= s_xr[CW-1:0];
            r_en   <= {rgt, lft, bot, top};
            r_seg  <= SEG_TOP;
            r_pos  <= lft ? (r_px - r_r) : '0;
        end else if (i_cmd.step) begin
            if (seg_last) begin
                r_seg <= t_seg'(r_seg + 2'd1);
                r_pos <= (r_seg == SEG_TOP) ? r_xlo : r_ylo;
            end else begin
                r_pos <= r_pos + CW'(1);
            end
        end
        r_p1_x  <= probe_x;
        r_p1_y  <= probe_y;
        r_p1_dx <= row_seg ? along_d : r_r;
        r_p1_dy <= row_seg ? r_r : along_d;
        r_p2_d  <= DW'(r_p1_dx) * DW'(r_p1_dx) + DW'(r_p1_dy) * DW'(r_p1_dy);
        r_p2_x  <= r_p1_x;
        r_p2_y  <= r_p1_y;
        if (i_cmd.emit) begin
            r_out_found <= r_best_valid;
            r_out_x     <= r_best_valid ? r_best_x[POS_W-1:0] : '0;
            r_out_y     <= r_best_valid ? r_best_y[POS_W-1:0] : '0;
            if (!r_best_valid) begin
                r_out_d <= '0;
            end else if (r_best_d > DW'(DIST_MAX)) begin
                r_out_d <= DIST_MAX;
            end else begin
                r_out_d <= r_best_d[DIST_W-1:0];
            end
        end
    end

    assign o_st.clr_last  = (r_clr_cnt == AW'(Depth - 1));
    assign o_st.stop      = !in_grid || (r_r >= maxdim) ||
                            (r_best_valid && (r_rsq >= r_best_d));
    assign o_st.seg_final = (r_seg == SEG_RGT) && seg_last;
    assign o_st.pipe_busy = r_p1_vld || r_p2_vld;
    assign o_st.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid       = r_out_vld;
    assign o_found           = r_out_found;
    assign o_nearest_x       = r_out_x;
    assign o_nearest_y       = r_out_y;
    assign o_nearest_dist_sq = r_out_d;

endmodule

/* src/nearest_obstacle_ring_search.sv */
// Nearest obstacle search over a one-bit occupancy grid of GRID_W x GRID_H cells held in a
// single-port-read RAM. After reset the block runs a clearing pass over all GRID_W*GRID_H
// cells, one cell per cycle, with s_axis_tready low; configuration writes are taken
// throughout. A write beat (tuser 0) writes one grid cell and gives no result. A query beat
// (tuser 1) reads one grid cell per cycle while it scans a ring, walking square rings of
// radius 1, 2 and so on around the query cell; each ring costs a step for each cell it holds
// inside the grid, a ring check, a step for each side that lies outside the grid, and a
// drain of the RAM read and distance stages. The walk ends once the ring radius squared
// reaches the best distance found or the radius reaches the larger grid dimension, and at
// once for a query cell outside the grid. Inputs are taken again as soon as the result sits
// in the output register, even while the sink stalls it.
`include "nearest_obstacle_ring_search_defines.svh"

module nearest_obstacle_ring_search
    import nors_pkg::*;
#(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_addr,
    input  logic [CW-1:0] i_cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [15:0]   s_axis_tdata,  // cell_x[5:0], cell_y[11:6], is_obstacle[12]
    input  logic          s_axis_tuser,  // kind
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [31:0]   m_axis_tdata,  // nearest_x[5:0], nearest_y[11:6], nearest_dist_sq[24:12]
    output logic          m_axis_tuser   // found
);

    t_cmd              cmd;
    t_status           st;
    logic [POS_W-1:0]  nearest_x, nearest_y;
    logic [DIST_W-1:0] nearest_dist_sq;

    nors_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .i_in_kind (s_axis_tuser),
        .o_in_ready(s_axis_tready),
        .i_st      (st),
        .o_cmd     (cmd)
    );

    nors_dp #(
        .GRID_W(GRID_W),
        .GRID_H(GRID_H)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cell_x         (s_axis_tdata[5:0]),
        .i_cell_y         (s_axis_tdata[11:6]),
        .i_is_obstacle    (s_axis_tdata[12]),
        .i_cmd            (cmd),
        .o_st             (st),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_found          (m_axis_tuser),
        .o_nearest_x      (nearest_x),
        .o_nearest_y      (nearest_y),
        .o_nearest_dist_sq(nearest_dist_sq)
    );

    assign m_axis_tdata = {7'b0, nearest_dist_sq, nearest_y, nearest_x};

    `NORS_ASSERT_IMP(a_miss_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 32'd0)
    `NORS_ASSERT_IMP(a_hit_not_self, m_axis_tvalid && m_axis_tuser, m_axis_tdata[24:12] != 13'd0)
    `NORS_ASSERT_IMP(a_idle_drained, s_axis_tready, !st.pipe_busy)
    `NORS_ASSERT_NXT(a_query_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready)

endmodule
